// File: design/otm_pkg.sv
// Shared types, widths and constants of the overdrive tone mix block.
package otm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int KNOB_W = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 17;
   localparam int GAIN_W = 20;
   localparam int MUL_W = 24;
   localparam int PROD_W = 48;
   localparam int TANH_W = 17;
   localparam int FRAC_W = 19;
   localparam int MAG_W = 19;
   localparam int X2_W = 18;

   localparam int ONE_Q16 = 65536;
   localparam int C_MOVE = 11796;
   localparam int C_BOOST = 14418;
   localparam int C_DECAY = 65208;
   localparam int GAIN_STEP = 13;
   localparam int ARG_LIMIT = 524288;

   localparam int TANH_TABLE_DEPTH_DEFAULT = 256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DRIVE_KNOB    = 3'd0,
      CSR_LOWPASS_COEFF = 3'd1,
      CSR_MIX_KNOB      = 3'd2,
      CSR_EXCITE_ON     = 3'd3,
      CSR_BYPASS_ON     = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ISSUE_NONE,
      ISSUE_MOVE,
      ISSUE_BOOST,
      ISSUE_DECAY,
      ISSUE_ARG,
      ISSUE_POS,
      ISSUE_INTERP,
      ISSUE_LPF,
      ISSUE_MIX
   } issue_op_type;

   typedef enum logic [3:0] {
      CAP_NONE,
      CAP_MOVE,
      CAP_BOOST,
      CAP_DECAY,
      CAP_ARG,
      CAP_POS,
      CAP_INTERP,
      CAP_LPF,
      CAP_MIX
   } capture_op_type;

   typedef struct packed {
      logic [KNOB_W-1:0] drive;
      logic [KNOB_W-1:0] alpha;
      logic [KNOB_W-1:0] mix;
      logic              excite;
      logic              bypass;
   } cfg_type;

   typedef struct packed {
      logic           load_in;
      issue_op_type   issue;
      capture_op_type capture;
      logic           load_out;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic out_free;
   } status_type;

endpackage

// File: design/otm_if.sv
// Word channel interfaces for the sample input and the processed sample output.
interface otm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [otm_pkg::SAMPLE_W-1:0] in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink (input valid, input in_sample, output ready);
endinterface

interface otm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [otm_pkg::SAMPLE_W-1:0] out_sample;

   modport source (output valid, output out_sample, input ready);
   modport sink (input valid, input out_sample, output ready);
endinterface

// File: design/overdrive_tone_mix_sample.sv
// Top level of the overdrive tone mix block: configuration, sequencer and datapath.
// Samples arrive as words on req_ch, a valid/ready channel carrying one signed
// Q1.15 sample, and leave as words on rsp_ch in the same format, one out per in.
// Settings are written through csr_wr_en, csr_index and csr_wr_data; the user
// must write them only while the block is idle, which the block does not enforce.
// An index beyond the register list is ignored. A sample is stepped through a
// chain of eight products, most depending on the one before, on the single shared
// 24 by 24 bit multiplier, each issued and written back in separate cycles.
// In bypass a word goes straight to the output register.
// The result sits in an output register, so a new word is accepted while the
// previous result still waits; if the receiver holds ready low, the block
// finishes the new word and then waits until the output register is free.
// Reset clears the filter and excite state, loads the register defaults and
// empties the output register; the tanh table is a constant and needs no fill.
module overdrive_tone_mix_sample #(
   parameter int TANH_TABLE_DEPTH = otm_pkg::TANH_TABLE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   otm_req_if.sink                          req_ch,
   otm_rsp_if.source                        rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [otm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [otm_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   otm_pkg::cfg_type    cfg;
   otm_pkg::cmd_type    cmd;
   otm_pkg::status_type status;

   otm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .index   (csr_index),
      .wr_data (csr_wr_data),
      .cfg     (cfg)
   );

   otm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   otm_datapath #(
      .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .in_sample  (req_ch.in_sample),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .out_sample (rsp_ch.out_sample)
   );

endmodule

// File: design/otm_csr.sv
// Configuration registers with write decode and knob clamping.
module otm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [otm_pkg::CSR_INDEX_W-1:0] index,
   input  logic [otm_pkg::CSR_DATA_W-1:0]  wr_data,
   output otm_pkg::cfg_type                 cfg
);

   localparam logic [otm_pkg::KNOB_W-1:0] KNOB_ONE = otm_pkg::KNOB_W'(otm_pkg::ONE_Q16);

   logic [otm_pkg::KNOB_W-1:0] drive_ff;
   logic [otm_pkg::KNOB_W-1:0] alpha_ff;
   logic [otm_pkg::KNOB_W-1:0] mix_ff;
   logic                       excite_ff;
   logic                       bypass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff  <= '0;
         alpha_ff  <= otm_pkg::KNOB_W'(6554);
         mix_ff    <= KNOB_ONE;
         excite_ff <= 1'b0;
         bypass_ff <= 1'b0;
      end else if (wr_en) begin
         case (otm_pkg::csr_index_type'(index))
            otm_pkg::CSR_DRIVE_KNOB: begin
               drive_ff <= wr_data;
            end
            otm_pkg::CSR_LOWPASS_COEFF: begin
               alpha_ff <= wr_data;
            end
            otm_pkg::CSR_MIX_KNOB: begin
               mix_ff <= wr_data;
            end
            otm_pkg::CSR_EXCITE_ON: begin
               excite_ff <= wr_data[0];
            end
            otm_pkg::CSR_BYPASS_ON: begin
               bypass_ff <= wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.drive  = (drive_ff > KNOB_ONE) ? KNOB_ONE : drive_ff;
      cfg.alpha  = (alpha_ff > KNOB_ONE) ? KNOB_ONE : alpha_ff;
      cfg.mix    = (mix_ff > KNOB_ONE) ? KNOB_ONE : mix_ff;
      cfg.excite = excite_ff;
      cfg.bypass = bypass_ff;
   end

endmodule

// File: design/otm_ctrl.sv
// Sequencer that steps one sample through the shared multiplier datapath.
module otm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  otm_pkg::status_type status,
   output otm_pkg::cmd_type    cmd
);

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_MOVE   = 16'h0002,
      ST_MOVE_WB = 16'h0004,
      ST_BOOST  = 16'h0008,
      ST_DECAY  = 16'h0010,
      ST_ARG    = 16'h0020,
      ST_MAG    = 16'h0040,
      ST_POS    = 16'h0080,
      ST_ROM    = 16'h0100,
      ST_INTERP = 16'h0200,
      ST_TANH   = 16'h0400,
      ST_LPF    = 16'h0800,
      ST_LPF_WB = 16'h1000,
      ST_MIX    = 16'h2000,
      ST_MIX_WB = 16'h4000,
      ST_DONE   = 16'h8000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.load_in  = 1'b0;
      cmd.issue    = otm_pkg::ISSUE_NONE;
      cmd.capture  = otm_pkg::CAP_NONE;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
            if (req_valid) begin
               state_in = status.bypass ? ST_DONE : ST_MOVE;
            end
         end
         ST_MOVE: begin
            cmd.issue = otm_pkg::ISSUE_MOVE;
            state_in  = ST_MOVE_WB;
         end
         ST_MOVE_WB: begin
            cmd.capture = otm_pkg::CAP_MOVE;
            state_in    = ST_BOOST;
         end
         ST_BOOST: begin
            cmd.issue = otm_pkg::ISSUE_BOOST;
            state_in  = ST_DECAY;
         end
         ST_DECAY: begin
            cmd.capture = otm_pkg::CAP_BOOST;
            cmd.issue   = otm_pkg::ISSUE_DECAY;
            state_in    = ST_ARG;
         end
         ST_ARG: begin
            cmd.capture = otm_pkg::CAP_DECAY;
            cmd.issue   = otm_pkg::ISSUE_ARG;
            state_in    = ST_MAG;
         end
         ST_MAG: begin
            cmd.capture = otm_pkg::CAP_ARG;
            state_in    = ST_POS;
         end
         ST_POS: begin
            cmd.issue = otm_pkg::ISSUE_POS;
            state_in  = ST_ROM;
         end
         ST_ROM: begin
            cmd.capture = otm_pkg::CAP_POS;
            state_in    = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.issue = otm_pkg::ISSUE_INTERP;
            state_in  = ST_TANH;
         end
         ST_TANH: begin
            cmd.capture = otm_pkg::CAP_INTERP;
            state_in    = ST_LPF;
         end
         ST_LPF: begin
            cmd.issue = otm_pkg::ISSUE_LPF;
            state_in  = ST_LPF_WB;
         end
         ST_LPF_WB: begin
            cmd.capture = otm_pkg::CAP_LPF;
            state_in    = ST_MIX;
         end
         ST_MIX: begin
            cmd.issue = otm_pkg::ISSUE_MIX;
            state_in  = ST_MIX_WB;
         end
         ST_MIX_WB: begin
            cmd.capture = otm_pkg::CAP_MIX;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            cmd.load_out = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/otm_datapath.sv
// Datapath: shared multiplier, tanh table, sample state and output register.
module otm_datapath #(
   parameter int TANH_TABLE_DEPTH = otm_pkg::TANH_TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  otm_pkg::cfg_type                     cfg,
   input  otm_pkg::cmd_type                     cmd,
   output otm_pkg::status_type                  status,
   input  logic signed [otm_pkg::SAMPLE_W-1:0] in_sample,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [otm_pkg::SAMPLE_W-1:0] out_sample
);

   localparam int PW = otm_pkg::PROD_W;
   localparam int MW = otm_pkg::MUL_W;
   localparam int SW = otm_pkg::SAMPLE_W;
   localparam int KW = otm_pkg::KNOB_W;
   localparam int TW = otm_pkg::TANH_W;
   localparam int IDX_W = $clog2(TANH_TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TANH_TABLE_DEPTH - 1);
   localparam logic [IDX_W-1:0] IDX_CLAMP = IDX_W'(TANH_TABLE_DEPTH - 2);
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   typedef logic [TW-1:0] tanh_tab_type [TANH_TABLE_DEPTH];

   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      int          b;
      q   = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic tanh_tab_type build_tanh();
      tanh_tab_type tab;
      logic [63:0]  a;
      logic [63:0]  term;
      logic [63:0]  r;
      logic [63:0]  y;
      logic [63:0]  num;
      int           k;
      int           i;
      a    = udiv(64'd16 << 30, 64'(TANH_TABLE_DEPTH - 1));
      term = ONE_Q30;
      r    = ONE_Q30;
      y    = ONE_Q30;
      for (k = 1; k < 64; k++) begin
         term = udiv((term * a) >> 30, 64'(k));
         if (k[0]) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      for (i = 0; i < TANH_TABLE_DEPTH; i++) begin
         if (i > 0) begin
            y = (y * r + (ONE_Q30 >> 1)) >> 30;
         end
         num    = (ONE_Q30 - y) * 64'd131072 + (ONE_Q30 + y);
         tab[i] = TW'(udiv(num, (ONE_Q30 + y) << 1));
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh();

   function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int sh);
      logic signed [PW-1:0] half;
      half = PW'(1) <<< (sh - 1);
      if (v >= 0) begin
         rnd = (v + half) >>> sh;
      end else begin
         rnd = -((-v + half) >>> sh);
      end
   endfunction

   function automatic logic signed [SW-1:0] sat16(input logic signed [PW-1:0] v);
      if (v > PW'(32767)) begin
         sat16 = 16'sh7FFF;
      end else if (v < -PW'(32768)) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[SW-1:0];
      end
   endfunction

   logic        [KW-1:0]               e_ff;
   logic signed [SW-1:0]               s_ff;
   logic signed [SW-1:0]               x_ff;
   logic        [otm_pkg::GAIN_W-1:0] gain_ff;
   logic signed [otm_pkg::X2_W-1:0]   x2_ff;
   logic        [otm_pkg::MAG_W-1:0]  mag_ff;
   logic                               neg_ff;
   logic                               sat_ff;
   logic        [TW-1:0]               lo_ff;
   logic        [TW-1:0]               hi_ff;
   logic        [otm_pkg::FRAC_W-1:0] frac_ff;
   logic signed [SW-1:0]               d_ff;
   logic signed [SW-1:0]               y_ff;
   logic signed [PW-1:0]               prod_ff;
   logic signed [SW-1:0]               out_ff;
   logic                               out_valid_ff;

   logic signed [MW-1:0]   mul_a;
   logic signed [MW-1:0]   mul_b;
   logic signed [PW-1:0]   prod_in;
   logic        [KW-1:0]   target;
   logic signed [KW:0]     e_diff;
   logic signed [KW:0]     lh_diff;
   logic signed [SW:0]     ds_diff;
   logic signed [SW:0]     sx_diff;
   logic signed [PW-1:0]   r16;
   logic signed [PW-1:0]   r19;
   logic signed [PW-1:0]   e_sum;
   logic        [KW-1:0]   e_move;
   logic signed [PW-1:0]   arg_mag;
   logic signed [PW-1:0]   tanh_mag;
   logic signed [PW-1:0]   tanh_val;
   logic        [IDX_W-1:0] idx_raw;
   logic        [IDX_W-1:0] idx;
   logic        [IDX_W-1:0] lo_addr;
   logic        [IDX_W-1:0] hi_addr;

   always_comb begin
      target  = cfg.excite ? KW'(otm_pkg::ONE_Q16) : '0;
      e_diff  = $signed({1'b0, target}) - $signed({1'b0, e_ff});
      lh_diff = $signed({1'b0, hi_ff}) - $signed({1'b0, lo_ff});
      ds_diff = (SW + 1)'(d_ff) - (SW + 1)'(s_ff);
      sx_diff = (SW + 1)'(s_ff) - (SW + 1)'(x_ff);
      mul_a   = '0;
      mul_b   = '0;
      case (cmd.issue)
         otm_pkg::ISSUE_MOVE: begin
            mul_a = MW'(otm_pkg::C_MOVE);
            mul_b = MW'(e_diff);
         end
         otm_pkg::ISSUE_BOOST: begin
            mul_a = MW'(otm_pkg::C_BOOST);
            mul_b = MW'($signed({1'b0, e_ff}));
         end
         otm_pkg::ISSUE_DECAY: begin
            mul_a = MW'(otm_pkg::C_DECAY);
            mul_b = MW'($signed({1'b0, e_ff}));
         end
         otm_pkg::ISSUE_ARG: begin
            mul_a = MW'(x2_ff);
            mul_b = MW'($signed({1'b0, gain_ff}));
         end
         otm_pkg::ISSUE_POS: begin
            mul_a = MW'($signed({1'b0, mag_ff}));
            mul_b = MW'(TANH_TABLE_DEPTH - 1);
         end
         otm_pkg::ISSUE_INTERP: begin
            mul_a = MW'(lh_diff);
            mul_b = MW'($signed({1'b0, frac_ff}));
         end
         otm_pkg::ISSUE_LPF: begin
            mul_a = MW'($signed({1'b0, cfg.alpha}));
            mul_b = MW'(ds_diff);
         end
         otm_pkg::ISSUE_MIX: begin
            mul_a = MW'($signed({1'b0, cfg.mix}));
            mul_b = MW'(sx_diff);
         end
         default: begin
         end
      endcase
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   always_comb begin
      r16   = rnd(prod_ff, 16);
      r19   = rnd(prod_ff, otm_pkg::FRAC_W);
      e_sum = $signed({{(PW - KW){1'b0}}, e_ff}) + r16;
      if (e_sum < 0) begin
         e_move = '0;
      end else if (e_sum > PW'(otm_pkg::ONE_Q16)) begin
         e_move = KW'(otm_pkg::ONE_Q16);
      end else begin
         e_move = e_sum[KW-1:0];
      end
      arg_mag  = (r16 < 0) ? -r16 : r16;
      tanh_mag = $signed({{(PW - TW){1'b0}}, lo_ff}) + r19;
      tanh_val = neg_ff ? -tanh_mag : tanh_mag;
      idx_raw  = prod_ff[otm_pkg::FRAC_W +: IDX_W];
      idx      = (idx_raw > IDX_CLAMP) ? IDX_CLAMP : idx_raw;
      lo_addr  = sat_ff ? IDX_LAST : idx;
      hi_addr  = sat_ff ? IDX_LAST : idx + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff <= '0;
         s_ff <= '0;
      end else begin
         case (cmd.capture)
            otm_pkg::CAP_MOVE: begin
               e_ff <= e_move;
            end
            otm_pkg::CAP_DECAY: begin
               e_ff <= prod_ff[16 +: KW];
            end
            otm_pkg::CAP_LPF: begin
               s_ff <= sat16(PW'(s_ff) + r16);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load_in) begin
         x_ff    <= in_sample;
         y_ff    <= in_sample;
         gain_ff <= otm_pkg::GAIN_W'(otm_pkg::ONE_Q16)
                    + otm_pkg::GAIN_W'(cfg.drive) * otm_pkg::GAIN_W'(otm_pkg::GAIN_STEP);
      end
      case (cmd.capture)
         otm_pkg::CAP_BOOST: begin
            x2_ff <= otm_pkg::X2_W'((PW'(x_ff) <<< 1) + r16);
         end
         otm_pkg::CAP_ARG: begin
            neg_ff <= r16 < 0;
            sat_ff <= arg_mag >= PW'(otm_pkg::ARG_LIMIT);
            mag_ff <= arg_mag[otm_pkg::MAG_W-1:0];
         end
         otm_pkg::CAP_POS: begin
            lo_ff   <= TANH_TAB[lo_addr];
            hi_ff   <= TANH_TAB[hi_addr];
            frac_ff <= sat_ff ? '0 : prod_ff[otm_pkg::FRAC_W-1:0];
         end
         otm_pkg::CAP_INTERP: begin
            d_ff <= sat16(rnd(tanh_val, 1));
         end
         otm_pkg::CAP_MIX: begin
            y_ff <= sat16(PW'(x_ff) + r16);
         end
         default: begin
         end
      endcase
      if (cmd.load_out) begin
         out_ff <= y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.bypass   = cfg.bypass;
   assign status.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign out_sample      = out_ff;

endmodule
